FILE: rtl/hrbd_pkg.sv
// ----------------------------------------------------------------------------
// hrbd_pkg: shared types and constants of the HTTP response body deframer
// Character constants, keyword tables, state encodings and the status bundle
// passed from the header parser to the top level.
// ----------------------------------------------------------------------------
package hrbd_pkg;

   localparam int LENGTH_BITS_DEF = 32;

   localparam int TE_LEN = 18;
   localparam int CL_LEN = 15;
   localparam int CW_LEN = 7;

   localparam logic [8*TE_LEN-1:0] TE_WORD = "transfer-encoding:";
   localparam logic [8*CL_LEN-1:0] CL_WORD = "content-length:";
   localparam logic [8*CW_LEN-1:0] CK_WORD = "chunked";

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_FRAMING = 2'd2,
      KIND_TRAILER = 2'd3
   } byte_kind_type;

   typedef enum logic [2:0] {
      ES_NORMAL = 3'b001,
      ES_LF     = 3'b010,
      ES_LFCR   = 3'b100
   } end_scan_type;

   typedef enum logic [4:0] {
      VM_NONE     = 5'b00001,
      VM_TE_SKIP  = 5'b00010,
      VM_TE_WORD  = 5'b00100,
      VM_CL_SKIP  = 5'b01000,
      VM_CL_DIGIT = 5'b10000
   } value_mode_type;

   typedef enum logic [4:0] {
      CP_GET_LEN   = 5'b00001,
      CP_SKIP_LF   = 5'b00010,
      CP_DATA      = 5'b00100,
      CP_SKIP_CRLF = 5'b01000,
      CP_NO_MORE   = 5'b10000
   } chunk_phase_type;

   typedef struct packed {
      logic header_done;      // before this byte
      logic chunked_mode;     // before this byte
      logic end_now;          // this byte closes the headers
      logic header_done_next;
      logic chunked_next;
      logic plain_done_next;  // length known and count at zero after this byte
   } hdr_status_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] pos);
      if (pos < 5'(TE_LEN)) te_char = TE_WORD[8*(TE_LEN-1-int'(pos)) +: 8];
      else te_char = 8'h00;
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] pos);
      if (pos < 5'(CL_LEN)) cl_char = CL_WORD[8*(CL_LEN-1-int'(pos)) +: 8];
      else cl_char = 8'h00;
   endfunction

   function automatic logic [7:0] ck_char(input logic [2:0] pos);
      if (pos < 3'(CW_LEN)) ck_char = CK_WORD[8*(CW_LEN-1-int'(pos)) +: 8];
      else ck_char = 8'h00;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] lc;
      lc = to_lower(c);
      if (c >= 8'h30 && c <= 8'h39) hex_val = {1'b1, c[3:0]};
      else if (lc >= 8'h61 && lc <= 8'h66) hex_val = {1'b1, lc[3:0] + 4'd9};
      else hex_val = 5'b0;
   endfunction

endpackage

FILE: rtl/hrbd_hdr.sv
// ----------------------------------------------------------------------------
// hrbd_hdr: header parser and content length tracker
// Finds the end of the headers, matches the encoding and length headers and
// counts a known content length down in plain mode.
// ----------------------------------------------------------------------------
module hrbd_hdr
   import hrbd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     byte_in,
   output hdr_status_type status
);

   logic                   hd_ff, hd_in;
   end_scan_type           es_ff, es_in;
   logic [4:0]             pos_ff, pos_in;
   logic [1:0]             cand_ff, cand_in;
   value_mode_type         vm_ff, vm_in;
   logic [2:0]             cw_ff, cw_in;
   logic                   enc_ff, enc_in;
   logic                   ck_ff, ck_in;
   logic                   known_ff, known_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;

   logic [7:0]             lc;
   logic                   is_lf, is_blank, is_digit;
   logic                   end_now;
   logic [2:0]             cw_eff, cw_inc;
   logic                   ck_hit;
   logic [1:0]             cand_live;
   logic [4:0]             pos_inc;
   logic [LENGTH_BITS+3:0] dec_sum;
   logic [LENGTH_BITS-1:0] dec_sat;

   assign lc       = to_lower(byte_in);
   assign is_lf    = (byte_in == CH_LF);
   assign is_blank = (byte_in == CH_SP) || (byte_in == CH_TAB);
   assign is_digit = (byte_in >= 8'h30) && (byte_in <= 8'h39);

   assign cw_eff = (vm_ff == VM_TE_SKIP) ? 3'd0 : cw_ff;
   assign cw_inc = cw_eff + 3'd1;
   assign ck_hit = (cw_eff < 3'(CW_LEN)) && (lc == ck_char(cw_eff));

   assign cand_live[0] = cand_ff[0] && (pos_ff < 5'(TE_LEN)) && (lc == te_char(pos_ff));
   assign cand_live[1] = cand_ff[1] && (pos_ff < 5'(CL_LEN)) && (lc == cl_char(pos_ff));
   assign pos_inc      = pos_ff + 5'd1;

   // times ten plus digit, saturating
   assign dec_sum = ({4'b0, rem_ff} << 3) + ({4'b0, rem_ff} << 1)
                  + {{LENGTH_BITS{1'b0}}, byte_in[3:0]};
   assign dec_sat = (dec_sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ?
                    {LENGTH_BITS{1'b1}} : dec_sum[LENGTH_BITS-1:0];

   always_comb begin
      hd_in    = hd_ff;
      es_in    = es_ff;
      pos_in   = pos_ff;
      cand_in  = cand_ff;
      vm_in    = vm_ff;
      cw_in    = cw_ff;
      enc_in   = enc_ff;
      ck_in    = ck_ff;
      known_in = known_ff;
      rem_in   = rem_ff;
      end_now  = 1'b0;
      if (!hd_ff) begin
         case (es_ff)
            ES_NORMAL: begin
               if (is_lf) es_in = ES_LF;
            end
            ES_LF: begin
               if (is_lf) end_now = 1'b1;
               else if (byte_in == CH_CR) es_in = ES_LFCR;
               else es_in = ES_NORMAL;
            end
            ES_LFCR: begin
               if (is_lf) end_now = 1'b1;
               else es_in = ES_NORMAL;
            end
            default: es_in = ES_NORMAL;
         endcase
         if (is_lf) begin
            pos_in  = 5'd0;
            cand_in = 2'b11;
            vm_in   = VM_NONE;
         end else begin
            case (vm_ff)
               VM_TE_SKIP, VM_TE_WORD: begin
                  if (!(vm_ff == VM_TE_SKIP && is_blank)) begin
                     if (ck_hit) begin
                        cw_in = cw_inc;
                        if (cw_inc == 3'(CW_LEN)) begin
                           ck_in = 1'b1;
                           vm_in = VM_NONE;
                        end else begin
                           vm_in = VM_TE_WORD;
                        end
                     end else begin
                        cw_in = cw_eff;
                        vm_in = VM_NONE;
                     end
                  end
               end
               VM_CL_SKIP, VM_CL_DIGIT: begin
                  if (!(vm_ff == VM_CL_SKIP && is_blank)) begin
                     if (is_digit) begin
                        rem_in = dec_sat;
                        vm_in  = VM_CL_DIGIT;
                     end else begin
                        vm_in = VM_NONE;
                     end
                  end
               end
               VM_NONE: begin
                  if (!enc_ff && cand_ff != 2'b00) begin
                     if (cand_live == 2'b00) begin
                        cand_in = 2'b00;
                     end else begin
                        pos_in  = pos_inc;
                        cand_in = cand_live;
                        if (cand_live[0] && pos_inc == 5'(TE_LEN)) begin
                           enc_in  = 1'b1;
                           cand_in = 2'b00;
                           vm_in   = VM_TE_SKIP;
                        end else if (cand_live[1] && pos_inc == 5'(CL_LEN)) begin
                           cand_in = 2'b00;
                           rem_in  = '0;
                           vm_in   = VM_CL_SKIP;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         if (end_now) begin
            hd_in    = 1'b1;
            es_in    = ES_NORMAL;
            known_in = (rem_in != '0);
         end
      end else if (!ck_ff) begin
         if (known_ff && rem_ff != '0) rem_in = rem_ff - LENGTH_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_ff    <= 1'b0;
         es_ff    <= ES_NORMAL;
         pos_ff   <= 5'd0;
         cand_ff  <= 2'b11;
         vm_ff    <= VM_NONE;
         cw_ff    <= 3'd0;
         enc_ff   <= 1'b0;
         ck_ff    <= 1'b0;
         known_ff <= 1'b0;
         rem_ff   <= '0;
      end else if (accept) begin
         hd_ff    <= hd_in;
         es_ff    <= es_in;
         pos_ff   <= pos_in;
         cand_ff  <= cand_in;
         vm_ff    <= vm_in;
         cw_ff    <= cw_in;
         enc_ff   <= enc_in;
         ck_ff    <= ck_in;
         known_ff <= known_in;
         rem_ff   <= rem_in;
      end
   end

   assign status.header_done      = hd_ff;
   assign status.chunked_mode     = ck_ff;
   assign status.end_now          = end_now;
   assign status.header_done_next = hd_in;
   assign status.chunked_next     = ck_in;
   assign status.plain_done_next  = known_in && (rem_in == '0);

endmodule

FILE: rtl/hrbd_chunk.sv
// ----------------------------------------------------------------------------
// hrbd_chunk: chunked body decoder
// Parses hex chunk sizes, classes framing, data and trailer bytes and flags
// stray bytes in the framing.
// ----------------------------------------------------------------------------
module hrbd_chunk
   import hrbd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          active,
   input  logic          clear,
   input  logic [7:0]    byte_in,
   output byte_kind_type kind,
   output logic          ferr,
   output logic          no_more_next
);

   chunk_phase_type        ph_ff, ph_in, ph_mid;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in, rem_mid, rem_dec;
   logic [4:0]             hex;
   logic [LENGTH_BITS+3:0] hex_sum;
   logic [LENGTH_BITS-1:0] hex_sat;
   logic                   is_lf, is_cr;

   assign hex     = hex_val(byte_in);
   assign is_lf   = (byte_in == CH_LF);
   assign is_cr   = (byte_in == CH_CR);
   assign hex_sum = {rem_ff, 4'b0} + {{LENGTH_BITS{1'b0}}, hex[3:0]};
   assign hex_sat = (hex_sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ?
                    {LENGTH_BITS{1'b1}} : hex_sum[LENGTH_BITS-1:0];
   assign rem_dec = rem_ff - LENGTH_BITS'(1);

   always_comb begin
      ph_mid  = ph_ff;
      rem_mid = rem_ff;
      if (ph_ff == CP_DATA && rem_ff == '0) ph_mid = CP_SKIP_CRLF;
      if (ph_mid == CP_GET_LEN) begin
         if (hex[4]) rem_mid = hex_sat;
         else ph_mid = CP_SKIP_LF;
      end
   end

   always_comb begin
      ph_in  = ph_mid;
      rem_in = rem_mid;
      kind   = KIND_FRAMING;
      ferr   = 1'b0;
      case (ph_mid)
         CP_GET_LEN: kind = KIND_FRAMING;
         CP_SKIP_LF: begin
            if (is_lf) ph_in = (rem_mid != '0) ? CP_DATA : CP_NO_MORE;
            else if (!is_cr && byte_in != CH_SP) ferr = 1'b1;
         end
         CP_DATA: begin
            kind   = KIND_DATA;
            rem_in = rem_dec;
            if (rem_dec == '0) ph_in = CP_SKIP_CRLF;
         end
         CP_SKIP_CRLF: begin
            if (is_lf) ph_in = CP_GET_LEN;
            else if (!is_cr) ferr = 1'b1;
         end
         default: kind = KIND_TRAILER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff  <= CP_GET_LEN;
         rem_ff <= '0;
      end else if (accept) begin
         if (clear) begin
            ph_ff  <= CP_GET_LEN;
            rem_ff <= '0;
         end else if (active) begin
            ph_ff  <= ph_in;
            rem_ff <= rem_in;
         end
      end
   end

   assign no_more_next = active && (ph_in == CP_NO_MORE);

endmodule

FILE: rtl/http_response_body_deframer.sv
// ----------------------------------------------------------------------------
// http_response_body_deframer: HTTP response header parser and body deframer
// The result of each input transfer is registered in the output register.
// Throughput: one byte per cycle; the input is taken whenever the output
// register is empty or is being emptied in the same cycle.
// Reset (synchronous, active high) empties the output register and returns
// the parser to the start of the headers with no length and no encoding.
// ----------------------------------------------------------------------------
module http_response_body_deframer
   import hrbd_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // segment_last
   // classified byte stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] byte_out, [8] headers_complete,
                                    // [9] chunked_flag, [10] body_done,
                                    // [11] framing_error, [15:12] zero
   output logic [1:0]  rsp_tuser,   // [1:0] byte_kind
   output logic        rsp_tlast    // segment_end
);

   logic           accept;
   hdr_status_type hdr;
   byte_kind_type  chunk_kind, kind;
   logic           chunk_ferr, chunk_no_more;
   logic           chunked_active;
   logic           ferr, done;

   logic           valid_ff, valid_in;
   logic [15:0]    data_ff, data_in;
   logic [1:0]     user_ff, user_in;
   logic           last_ff, last_in;

   // take a new byte whenever the result register frees up this cycle
   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   hrbd_hdr #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_hdr (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .byte_in (req_tdata),
      .status  (hdr)
   );

   // the chunk decoder runs only once the headers are done and chunked won
   assign chunked_active = hdr.header_done && hdr.chunked_mode;

   hrbd_chunk #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_chunk (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .active       (chunked_active),
      .clear        (hdr.end_now),
      .byte_in      (req_tdata),
      .kind         (chunk_kind),
      .ferr         (chunk_ferr),
      .no_more_next (chunk_no_more)
   );

   // class the byte: header, plain body, or what the chunk decoder says
   always_comb begin
      if (!hdr.header_done) kind = KIND_HEADER;
      else if (!hdr.chunked_mode) kind = KIND_DATA;
      else kind = chunk_kind;
   end

   assign ferr = chunked_active && chunk_ferr;

   // completion is judged on the state after this byte
   assign done = hdr.header_done_next &&
                 (hdr.chunked_next ? chunk_no_more : hdr.plain_done_next);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = {4'b0, ferr, done, hdr.chunked_next, hdr.header_done_next, req_tdata};
         user_in  = kind;
         last_in  = req_tlast;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   // payload needs no reset; load on each transfer
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   // once the headers are closed they stay closed until reset
   a_headers_sticky: assert property (@(posedge clock) disable iff (reset)
      hdr.header_done |=> hdr.header_done)
      else $error("header_done dropped without reset");

   // a framing error can only come from the chunk decoder
   a_ferr_chunked: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff[11]) |-> (data_ff[9] && data_ff[8]))
      else $error("framing_error outside chunked body");

   // non-header kinds only after the headers
   a_kind_after_hdr: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && user_ff != KIND_HEADER) |-> data_ff[8])
      else $error("body kind before end of headers");

   // body_done never before the headers are closed
   a_done_after_hdr: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff[10]) |-> data_ff[8])
      else $error("body_done before end of headers");

   // trailer bytes exist only in chunked mode and only after the last chunk
   a_trailer_done: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && user_ff == KIND_TRAILER) |-> (data_ff[9] && data_ff[10]))
      else $error("trailer byte without finished chunked body");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the HTTP response body deframer
// Streams one response through the block: directed and random header lines,
// the encoding header, more random lines, then a chunked or plain body picked
// per seed. Every result transfer is checked against a bit-exact prediction.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hrbd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_TOTAL   = 1300;
   localparam int QUIET_SPAN   = 200;   // body transfers with no idling at all

   localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS_DEF);

   // end-of-headers scan
   localparam logic [1:0] SCAN_TEXT  = 2'd0;
   localparam logic [1:0] SCAN_LF    = 2'd1;
   localparam logic [1:0] SCAN_LF_CR = 2'd2;

   // header value parsing
   localparam logic [2:0] VAL_NONE      = 3'd0;
   localparam logic [2:0] VAL_TE_BLANK  = 3'd1;
   localparam logic [2:0] VAL_TE_WORD   = 3'd2;
   localparam logic [2:0] VAL_CL_BLANK  = 3'd3;
   localparam logic [2:0] VAL_CL_DIGITS = 3'd4;

   // keyword candidate bits
   localparam int TE_BIT = 0;
   localparam int CL_BIT = 1;

   // chunked body phases
   localparam logic [2:0] PH_SIZE     = 3'd0;
   localparam logic [2:0] PH_SIZE_EOL = 3'd1;
   localparam logic [2:0] PH_DATA     = 3'd2;
   localparam logic [2:0] PH_DATA_EOL = 3'd3;
   localparam logic [2:0] PH_DONE     = 3'd4;

   // one result transfer, in the bit order of {rsp_tdata, rsp_tuser, rsp_tlast}
   typedef struct packed {
      logic [3:0]    pad;
      logic          ferr;
      logic          done;
      logic          chunked;
      logic          hdr;
      logic [7:0]    octet;
      byte_kind_type kind;
      logic          seg_end;
   } deframed_octet_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] byte_in
   logic        req_tlast  = 1'b0;    // segment_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] byte_out, [8] headers_complete,
                                      // [9] chunked_flag, [10] body_done,
                                      // [11] framing_error, [15:12] zero
   logic [1:0]  rsp_tuser;            // [1:0] byte_kind
   logic        rsp_tlast;            // segment_end

   bit throttle = 1'b1;               // random idling on both sides
   int octets_sent   = 0;
   int results_seen  = 0;
   int fault_count   = 0;
   int cycle_count   = 0;

   deframed_octet_type expected_octets[$];

   string te_key = "transfer-encoding:";
   string cl_key = "content-length:";
   string ck_key = "chunked";
   string wrong_codings[5] = '{"identity", "chunke", "gzip, chunked", "", "chunk ed"};

   // deframer state as predicted by the bench
   bit          hdr_done   = 1'b0;
   logic [1:0]  scan       = SCAN_TEXT;
   logic [4:0]  key_pos    = 5'd0;
   logic [1:0]  key_live   = 2'b11;
   logic [2:0]  value_mode = VAL_NONE;
   logic [2:0]  word_pos   = 3'd0;
   bit          enc_seen   = 1'b0;
   bit          chunked    = 1'b0;
   bit          len_known  = 1'b0;
   logic [63:0] body_left  = 64'd0;
   logic [2:0]  phase      = PH_SIZE;
   logic [63:0] chunk_left = 64'd0;

   http_response_body_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Predict the result of one accepted byte and advance the predicted state.
   function automatic deframed_octet_type classify_octet(input logic [7:0] c, input logic seg);
      deframed_octet_type r;
      logic [7:0]    lc;
      logic [63:0]   d;
      byte_kind_type kind;
      logic          ferr;
      logic          closes;
      logic          blank;
      logic          is_hex;
      kind   = KIND_HEADER;
      ferr   = 1'b0;
      closes = 1'b0;
      lc     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      blank  = (c == CH_SP || c == CH_TAB);
      if (!hdr_done) begin
         // watch for LF LF or LF CR LF
         case (scan)
            SCAN_TEXT: if (c == CH_LF) scan = SCAN_LF;
            SCAN_LF: begin
               if (c == CH_LF) closes = 1'b1;
               else scan = (c == CH_CR) ? SCAN_LF_CR : SCAN_TEXT;
            end
            default: begin
               if (c == CH_LF) closes = 1'b1;
               else scan = SCAN_TEXT;
            end
         endcase
         if (c == CH_LF) begin
            // every value ends at the line end; restart keyword matching
            key_pos    = 5'd0;
            key_live   = 2'b11;
            value_mode = VAL_NONE;
         end else begin
            if (value_mode == VAL_TE_BLANK && !blank) begin
               value_mode = VAL_TE_WORD;
               word_pos   = 3'd0;
            end
            if (value_mode == VAL_CL_BLANK && !blank) value_mode = VAL_CL_DIGITS;
            case (value_mode)
               VAL_TE_BLANK, VAL_CL_BLANK: ;
               VAL_TE_WORD: begin
                  if (word_pos < ck_key.len() && lc == ck_key[word_pos]) begin
                     word_pos = word_pos + 3'd1;
                     if (word_pos == ck_key.len()) begin
                        chunked    = 1'b1;
                        value_mode = VAL_NONE;
                     end
                  end else begin
                     value_mode = VAL_NONE;
                  end
               end
               VAL_CL_DIGITS: begin
                  if (c >= "0" && c <= "9") begin
                     d = 64'(c - "0");
                     if (body_left > (LEN_MAX - d) / 10) body_left = LEN_MAX;
                     else body_left = body_left * 10 + d;
                  end else begin
                     value_mode = VAL_NONE;
                  end
               end
               default: begin
                  if (!enc_seen && key_live != 2'b00) begin
                     if (key_live[TE_BIT] && !(key_pos < te_key.len() && lc == te_key[key_pos]))
                        key_live[TE_BIT] = 1'b0;
                     if (key_live[CL_BIT] && !(key_pos < cl_key.len() && lc == cl_key[key_pos]))
                        key_live[CL_BIT] = 1'b0;
                     if (key_live != 2'b00) begin
                        key_pos = key_pos + 5'd1;
                        if (key_live[TE_BIT] && key_pos == te_key.len()) begin
                           enc_seen   = 1'b1;
                           key_live   = 2'b00;
                           value_mode = VAL_TE_BLANK;
                        end else if (key_live[CL_BIT] && key_pos == cl_key.len()) begin
                           key_live   = 2'b00;
                           body_left  = 64'd0;
                           value_mode = VAL_CL_BLANK;
                        end
                     end
                  end
               end
            endcase
         end
         if (closes) begin
            hdr_done   = 1'b1;
            scan       = SCAN_TEXT;
            len_known  = (body_left != 0);
            phase      = PH_SIZE;
            chunk_left = 64'd0;
         end
      end else if (!chunked) begin
         kind = KIND_DATA;
         if (len_known && body_left > 0) body_left = body_left - 1;
      end else begin
         if (phase == PH_DATA && chunk_left == 0) phase = PH_DATA_EOL;
         if (phase == PH_SIZE) begin
            kind   = KIND_FRAMING;
            is_hex = 1'b1;
            if (c >= "0" && c <= "9") d = 64'(c - "0");
            else if (lc >= "a" && lc <= "f") d = 64'(lc - "a" + 8'd10);
            else is_hex = 1'b0;
            if (!is_hex) phase = PH_SIZE_EOL;
            else if (chunk_left > ((LEN_MAX - d) >> 4)) chunk_left = LEN_MAX;
            else chunk_left = (chunk_left << 4) + d;
         end
         if (phase == PH_SIZE_EOL) begin
            kind = KIND_FRAMING;
            if (c == CH_LF) phase = (chunk_left > 0) ? PH_DATA : PH_DONE;
            else if (c != CH_CR && c != CH_SP) ferr = 1'b1;
         end else if (phase == PH_DATA) begin
            kind       = KIND_DATA;
            chunk_left = chunk_left - 1;
            if (chunk_left == 0) phase = PH_DATA_EOL;
         end else if (phase == PH_DATA_EOL) begin
            kind = KIND_FRAMING;
            if (c == CH_LF) phase = PH_SIZE;
            else if (c != CH_CR) ferr = 1'b1;
         end else if (phase >= PH_DONE) begin
            kind = KIND_TRAILER;
         end
      end
      r.pad     = 4'd0;
      r.ferr    = ferr;
      r.done    = hdr_done && (chunked ? (phase >= PH_DONE) : (len_known && body_left == 0));
      r.chunked = chunked;
      r.hdr     = hdr_done;
      r.octet   = c;
      r.kind    = kind;
      r.seg_end = seg;
      return r;
   endfunction

   function automatic string describe(input deframed_octet_type r);
      return $sformatf("byte %02h kind %0d hdr %b chunked %b done %b ferr %b last %b pad %h",
                       r.octet, r.kind, r.hdr, r.chunked, r.done, r.ferr, r.seg_end, r.pad);
   endfunction

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   function automatic string mix_case(input string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++)
         if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1)) r[i] = r[i] - 8'd32;
      return r;
   endfunction

   function automatic string blanks();
      string r;
      string b;
      r = "";
      repeat ($urandom_range(0, 3)) begin
         b = $urandom_range(1) ? " " : "\t";
         r = {r, b};
      end
      return r;
   endfunction

   function automatic string line_end();
      return ($urandom_range(3) == 0) ? "\n" : "\r\n";
   endfunction

   // Offer one byte, hold it until the transfer, then log its prediction.
   task automatic send_octet(input logic [7:0] c);
      logic seg;
      seg = ($urandom_range(7) == 0);
      if (throttle && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= seg;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_octets.push_back(classify_octet(c, seg));
      octets_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_octet(s[i]);
   endtask

   // Send a chunk size in hex, random letter case, with optional leading zeros.
   task automatic send_hex(input logic [63:0] v, input int zeros);
      int         digits;
      logic [3:0] nib;
      digits = 1;
      while (digits < 16 && (v >> (4 * digits)) != 0) digits++;
      repeat (zeros) send_octet("0");
      for (int i = digits - 1; i >= 0; i--) begin
         nib = v[4*i +: 4];
         if (nib < 10) send_octet(8'h30 + nib);
         else send_octet(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10);
      end
   endtask

   // Send a Content-Length line with the given value text.
   task automatic send_length_line(input string value);
      send_text(mix_case(cl_key));
      send_text(blanks());
      send_text(value);
      send_text(line_end());
   endtask

   // Hand-picked header lines: empty values, signs, saturation, near misses.
   task automatic test_header_directed();
      send_text("HTTP/1.1 200 OK\r\n");
      send_text("content-length:\r\n");
      send_text("Content-Length: \t \n");
      send_text("CONTENT-LENGTH: +42\r\n");
      send_text("Content-Length:\t99999999999\r\n");
      send_text("Content-Lengthx: 7\r\n");
      send_text("Transfer-Encodin: chunked\r\n");
      send_text("\rX-Pad: 1\r\n");
      send_text("Content-Length: 12-3\r\n");
   endtask

   // Random header lines: noise, length lines, broken keywords.
   task automatic test_random_headers(input int lines);
      logic [7:0] c;
      string      key;
      int         cut;
      repeat (lines) begin
         case ($urandom_range(5))
            0, 1: begin
               // first byte never CR or LF, so the line cannot close the headers
               do c = 8'($urandom_range(255)); while (c == CH_LF || c == CH_CR);
               send_octet(c);
               repeat ($urandom_range(0, 30)) begin
                  do c = 8'($urandom_range(255)); while (c == CH_LF);
                  send_octet(c);
               end
               send_text(line_end());
            end
            2, 3: begin
               case ($urandom_range(9))
                  0: send_length_line($sformatf("%s%0d", $urandom_range(1) ? "+" : "-",
                                                $urandom_range(0, 999)));
                  1: send_length_line($sformatf("%0d%0d", $urandom_range(1, 999999),
                                                $urandom_range(100000, 999999)));
                  2: send_length_line("");
                  3: send_length_line($sformatf("%0d;x", $urandom_range(0, 700)));
                  default: send_length_line($sformatf("%0d", $urandom_range(0, 700)));
               endcase
            end
            default: begin
               // keyword prefix, then one to six random bytes other than LF
               key = $urandom_range(1) ? te_key : cl_key;
               cut = $urandom_range(1, key.len() - 1);
               send_text(mix_case(key.substr(0, cut - 1)));
               repeat ($urandom_range(1, 6)) begin
                  do c = 8'($urandom_range(255)); while (c == CH_LF);
                  send_octet(c);
               end
               send_text(line_end());
            end
         endcase
      end
   endtask

   // The encoding header, optional in plain mode, where a final length line comes first.
   task automatic test_encoding_header(input bit chunk_it);
      if (!chunk_it)
         send_length_line($sformatf("%0d", ($urandom_range(5) == 0) ? 0 :
                                           $urandom_range(1, 600)));
      if (chunk_it || $urandom_range(2) != 0) begin
         send_text(mix_case(te_key));
         send_text(blanks());
         if (chunk_it) begin
            send_text(mix_case(ck_key));
            if ($urandom_range(1)) send_text(", gzip");
         end else begin
            send_text(wrong_codings[$urandom_range(4)]);
         end
         send_text(line_end());
      end
   endtask

   // Chunked body: random chunks with damaged framing, then an end or overflow.
   task automatic test_chunked_body();
      int         body_start;
      int         chunk_len;
      logic [7:0] c;
      body_start = octets_sent;
      while (octets_sent < ITEM_TOTAL) begin
         throttle  = (octets_sent >= body_start + QUIET_SPAN);
         chunk_len = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
         send_hex(64'(chunk_len), ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
         case ($urandom_range(5))
            0: send_text(" \r\n");
            1: send_text(";ext=v\r\n");
            2: send_text("\n");
            3: send_text("G\r\n");
            default: send_text("\r\n");
         endcase
         repeat (chunk_len) send_octet(8'($urandom_range(255)));
         case ($urandom_range(5))
            0: send_text("\n");
            1: begin
               do c = 8'($urandom_range(255)); while (c == CH_LF);
               send_octet(c);
               send_text("\r\n");
            end
            2: send_text("\r\r\n");
            default: send_text("\r\n");
         endcase
      end
      if ($urandom_range(2) == 0) begin
         // size saturates, so the body never ends
         send_text(mix_case("fffffffff1"));
         send_text("\r\n");
         repeat (40) send_octet(8'($urandom_range(255)));
      end else begin
         send_hex(64'd0, $urandom_range(0, 2));
         send_text($urandom_range(1) ? "\r\n" : ";last\r\n");
         repeat ($urandom_range(20, 40)) send_octet(8'($urandom_range(255)));
      end
   endtask

   // Plain body: random bytes, running past the content length.
   task automatic test_plain_body();
      int body_start;
      body_start = octets_sent;
      while (octets_sent < ITEM_TOTAL) begin
         throttle = (octets_sent >= body_start + QUIET_SPAN);
         send_octet(8'($urandom_range(255)));
      end
   endtask

   // Stall the result side at random.
   always @(posedge clock) begin
      rsp_tready <= !(throttle && $urandom_range(99) < 24);
   end

   // Check each result transfer against the oldest prediction.
   always @(posedge clock) begin
      deframed_octet_type got;
      deframed_octet_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = deframed_octet_type'({rsp_tdata, rsp_tuser, rsp_tlast});
         if (expected_octets.size() == 0) begin
            log_fault($sformatf("result %0d with nothing pending: %s",
                                results_seen, describe(got)));
         end else begin
            want = expected_octets.pop_front();
            if (got !== want)
               log_fault($sformatf("result %0d mismatch: expected %s; got %s",
                                   results_seen, describe(want), describe(got)));
         end
         results_seen++;
      end
   end

   // Bound the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      bit use_chunked;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      use_chunked = $urandom_range(1);
      test_header_directed();
      test_random_headers(14);
      test_encoding_header(use_chunked);
      // matching has stopped if an encoding header was seen
      test_random_headers(4);
      // blank line closes the headers
      send_text(line_end());
      if (use_chunked) test_chunked_body();
      else test_plain_body();
      req_tvalid <= 1'b0;
      // drain the predictions, then allow for stray results
      while (expected_octets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: sim.f
rtl/hrbd_pkg.sv
rtl/hrbd_hdr.sv
rtl/hrbd_chunk.sv
rtl/http_response_body_deframer.sv
tb/tb_top.sv
